### hdl/ued_pkg.sv
// types, constants and helpers for the backslash-u escape decoder
// no dependencies
package ued_pkg;

  localparam int unsigned CHAR_W     = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned TAKEN_W    = 3;
  localparam int unsigned OUT_DEPTH  = 3;
  localparam int unsigned CNT_W      = 2;

  localparam logic [CHAR_W-1:0]  CH_BACKSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0]  CH_LOWER_U   = 16'h0075;
  localparam logic [TAKEN_W-1:0] ESC_DIGITS   = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_PENDING = 2'd1,
    MODE_ESCAPE  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              end_of_text;
  } ued_beat_t;

  typedef struct packed {
    logic               is_hex;
    logic [DIGIT_W-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [CHAR_W-1:0] c);
    hex_digit_t r;
    logic [CHAR_W-1:0] t;
    r = '0;
    t = '0;
    if (c inside {[16'h0030 : 16'h0039]}) begin
      t = c - 16'h0030;
      r.is_hex = 1'b1;
    end else if (c inside {[16'h0061 : 16'h0066]}) begin
      t = c - 16'h0057;
      r.is_hex = 1'b1;
    end else if (c inside {[16'h0041 : 16'h0046]}) begin
      t = c - 16'h0037;
      r.is_hex = 1'b1;
    end
    r.value = t[DIGIT_W-1:0];
    return r;
  endfunction

endpackage

### hdl/ued_in_if.sv
// input channel of the escape decoder: one escaped character per beat
// depends on ued_pkg
interface ued_in_if import ued_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

### hdl/ued_out_if.sv
// output channel of the escape decoder: one decoded code unit per beat
// depends on ued_pkg
interface ued_out_if import ued_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              end_of_text;

  modport source (output valid, output char_out, output end_of_text, input ready);
  modport sink   (input valid, input char_out, input end_of_text, output ready);
endinterface

### hdl/unicode_escape_decoder.sv
// backslash-u escape decoder top level: decode state plus a three-beat output queue
// depends on ued_pkg, ued_in_if, ued_out_if
//
//   channel  dir  beat                       handshake
//   in_i     in   char_in[15:0], last_in     valid/ready
//   out_o    out  char_out[15:0], end_of_text valid/ready
//
// one character is taken per cycle; its zero, one or two results go into the
// output queue in the same edge and the head shows on out_o the cycle after.
// in_i.ready is high while the queue holds at most one beat, so a steady
// stream runs at one character per cycle; a two-result character drops
// in_i.ready for the next cycle, and for longer while out_o is not drained.
// reset clears the decode state and empties the queue.
module unicode_escape_decoder import ued_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ued_in_if.sink   in_i,
  ued_out_if.source out_o
);

  mode_e              mode_q, mode_d;
  logic [TAKEN_W-1:0] taken_q, taken_d;
  logic [CHAR_W-1:0]  hex_q, hex_d;
  logic               stopped_q, stopped_d;

  ued_beat_t          slot_q [OUT_DEPTH];
  ued_beat_t          slot_d [OUT_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               accept, pop;
  logic [1:0]         n_res;
  ued_beat_t          res0, res1;
  hex_digit_t         dig;
  logic [CHAR_W-1:0]  hex_nx;
  logic [TAKEN_W-1:0] taken_nx;
  logic [CNT_W-1:0]   base;

  assign in_i.ready        = (cnt_q <= CNT_W'(1));
  assign accept            = in_i.valid & in_i.ready;
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.char_out    = slot_q[0].char_out;
  assign out_o.end_of_text = slot_q[0].end_of_text;
  assign pop               = out_o.valid & out_o.ready;
  assign dig               = hex_digit(in_i.char_in);

  // decode of the accepted character
  always_comb begin
    mode_d    = mode_q;
    taken_d   = taken_q;
    hex_d     = hex_q;
    stopped_d = stopped_q;
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    hex_nx    = hex_q;
    taken_nx  = taken_q + TAKEN_W'(1);

    if (!stopped_q && dig.is_hex) begin
      hex_nx = {hex_q[CHAR_W-DIGIT_W-1:0], dig.value};
    end

    if (accept) begin
      case (mode_q)
        MODE_PENDING: begin
          if (in_i.char_in == CH_LOWER_U) begin
            mode_d    = MODE_ESCAPE;
            taken_d   = '0;
            hex_d     = '0;
            stopped_d = 1'b0;
            if (in_i.last_in) begin
              n_res = 2'd1;
              res0  = '{char_out: '0, end_of_text: 1'b1};
            end
          end else begin
            mode_d = MODE_NORMAL;
            res0   = '{char_out: CH_BACKSLASH, end_of_text: 1'b0};
            n_res  = 2'd1;
            if (in_i.char_in == CH_BACKSLASH && !in_i.last_in) begin
              mode_d = MODE_PENDING;
            end else begin
              n_res = 2'd2;
              res1  = '{char_out: in_i.char_in, end_of_text: in_i.last_in};
            end
          end
        end
        MODE_ESCAPE: begin
          hex_d     = hex_nx;
          stopped_d = stopped_q | ~dig.is_hex;
          taken_d   = taken_nx;
          if (taken_nx >= ESC_DIGITS || in_i.last_in) begin
            n_res     = 2'd1;
            res0      = '{char_out: hex_nx, end_of_text: in_i.last_in};
            mode_d    = MODE_NORMAL;
            taken_d   = '0;
            hex_d     = '0;
            stopped_d = 1'b0;
          end
        end
        default: begin
          // normal mode, and the unused code behaves the same
          mode_d = MODE_NORMAL;
          if (in_i.char_in == CH_BACKSLASH && !in_i.last_in) begin
            mode_d = MODE_PENDING;
          end else begin
            n_res = 2'd1;
            res0  = '{char_out: in_i.char_in, end_of_text: in_i.last_in};
          end
        end
      endcase

      if (in_i.last_in) begin
        mode_d    = MODE_NORMAL;
        taken_d   = '0;
        hex_d     = '0;
        stopped_d = 1'b0;
      end
    end
  end

  // output queue: head in slot 0, shift on pop, append behind the survivors
  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      slot_d[i] = slot_q[i];
    end
    base = cnt_q;
    if (pop) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      base = cnt_q - CNT_W'(1);
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (n_res != 2'd0 && base == CNT_W'(i)) begin
        slot_d[i] = res0;
      end
      if (n_res == 2'd2 && base + CNT_W'(1) == CNT_W'(i)) begin
        slot_d[i] = res1;
      end
    end
    cnt_d = base + CNT_W'(n_res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      taken_q   <= '0;
      hex_q     <= '0;
      stopped_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      taken_q   <= taken_d;
      hex_q     <= hex_d;
      stopped_q <= stopped_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for the backslash-u escape decoder: random texts, checked per beat
// depends on ued_pkg, ued_in_if, ued_out_if and unicode_escape_decoder
module testbench;
  import ued_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned TARGET_CHARS   = 450;
  localparam int unsigned RADIX          = 16;
  localparam int unsigned NOT_HEX        = RADIX;
  localparam int unsigned STALL_AT       = 330;
  localparam int unsigned STALL_LEN      = 60;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              fin;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ued_in_if  in_if ();
  ued_out_if out_if ();

  unicode_escape_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_char_t  text_q[$];
  ued_beat_t   decoded_q[$];

  // decoder state mirrored by the predictor
  mode_e              esc_mode;
  logic [TAKEN_W-1:0] esc_taken;
  logic [CHAR_W-1:0]  esc_value;
  logic               esc_stopped;

  int unsigned mismatches;
  int unsigned chars_sent;
  int unsigned chars_taken;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          stall_done;
  int unsigned tx_idle;
  int unsigned rx_idle;
  text_char_t  next_char;
  ued_beat_t   want;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned digit_of(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) return c - 16'h0030;
    if (c >= 16'h0061 && c <= 16'h0066) return c - 16'h0061 + 10;
    if (c >= 16'h0041 && c <= 16'h0046) return c - 16'h0041 + 10;
    return NOT_HEX;
  endfunction

  task automatic push_unit(input logic [CHAR_W-1:0] u, input logic eot);
    ued_beat_t b;
    b.char_out    = u;
    b.end_of_text = eot;
    decoded_q = {decoded_q, b};
  endtask

  task automatic clear_escape();
    esc_mode    = MODE_NORMAL;
    esc_taken   = '0;
    esc_value   = '0;
    esc_stopped = 1'b0;
  endtask

  task automatic plain_char(input logic [CHAR_W-1:0] c, input logic fin);
    if (c == CH_BACKSLASH) begin
      if (fin) push_unit(CH_BACKSLASH, 1'b1);
      else esc_mode = MODE_PENDING;
    end else begin
      push_unit(c, fin);
    end
  endtask

  // expected decoded units for one accepted character
  task automatic decode_char(input logic [CHAR_W-1:0] c, input logic fin);
    int unsigned d;
    case (esc_mode)
      MODE_PENDING: begin
        if (c == CH_LOWER_U) begin
          clear_escape();
          esc_mode = MODE_ESCAPE;
          if (fin) push_unit('0, 1'b1);
        end else begin
          esc_mode = MODE_NORMAL;
          push_unit(CH_BACKSLASH, 1'b0);
          plain_char(c, fin);
        end
      end
      MODE_ESCAPE: begin
        d = digit_of(c);
        if (!esc_stopped && d < RADIX) esc_value = CHAR_W'(esc_value * RADIX + d);
        else esc_stopped = 1'b1;
        esc_taken = esc_taken + 1'b1;
        if (esc_taken >= ESC_DIGITS || fin) begin
          push_unit(esc_value, fin);
          clear_escape();
        end
      end
      default: begin
        esc_mode = MODE_NORMAL;
        plain_char(c, fin);
      end
    endcase
    if (fin) clear_escape();
  endtask

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic fin);
    text_char_t t;
    t.code = c;
    t.fin  = fin;
    text_q = {text_q, t};
  endtask

  task automatic add_text(input string s, input bit ends_text);
    for (int i = 0; i < s.len(); i++)
      add_char(CHAR_W'(s[i]), ends_text && (i == s.len() - 1));
  endtask

  // a text built from escapes, broken escapes and plain characters, sometimes cut short
  task automatic add_random_text();
    string             hex_set;
    string             edge_set;
    logic [CHAR_W-1:0] body[$];
    logic [CHAR_W-1:0] ch;
    int unsigned       tokens;
    int unsigned       pick;
    hex_set  = "0123456789abcdefABCDEF";
    edge_set = "/:@G`g -x";
    tokens   = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        body = {body, CH_BACKSLASH, CH_LOWER_U};
        for (int k = 0; k < ESC_DIGITS; k++) begin
          pick = $urandom_range(99);
          if (pick < 80) ch = CHAR_W'(hex_set[$urandom_range(hex_set.len() - 1)]);
          else if (pick < 92) ch = CHAR_W'(edge_set[$urandom_range(edge_set.len() - 1)]);
          else ch = CHAR_W'($urandom);
          body = {body, ch};
        end
      end else if (pick < 65) begin
        pick = $urandom_range(3);
        if (pick == 0) ch = CH_BACKSLASH;
        else if (pick == 1) ch = CHAR_W'(hex_set[$urandom_range(hex_set.len() - 1)]);
        else ch = CHAR_W'($urandom);
        body = {body, CH_BACKSLASH, ch};
      end else if (pick < 80) begin
        ch   = CHAR_W'($urandom);
        body = {body, ch};
      end else begin
        ch   = CHAR_W'($urandom_range(16'h0020, 16'h007E));
        body = {body, ch};
      end
    end
    if ($urandom_range(4) == 0 && body.size() > 1) begin
      pick = $urandom_range(1, body.size() - 1);
      repeat (pick) void'(body.pop_back());
    end
    foreach (body[i]) add_char(body[i], i == body.size() - 1);
  endtask

  // sender: offers queued characters, idling at random per phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.char_in <= '0;
      in_if.last_in <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      tx_idle = (chars_sent < 150) ? 23 : (chars_sent < 300) ? 62 : 0;
      if (text_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        next_char = text_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.char_in <= next_char.code;
        in_if.last_in <= next_char.fin;
        chars_sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: checks output beats, then predicts from the input beat of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h end %b",
                                    out_if.char_out, out_if.end_of_text));
        end else begin
          want = decoded_q.pop_front();
          if (out_if.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %h, expected %h",
                                      out_if.char_out, want.char_out));
          if (out_if.end_of_text !== want.end_of_text)
            report_mismatch($sformatf("end_of_text %b, expected %b on unit %h",
                                      out_if.end_of_text, want.end_of_text, want.char_out));
        end
      end
      if (in_if.valid && in_if.ready) begin
        decode_char(in_if.char_in, in_if.last_in);
        chars_taken++;
      end
      // one long hold-off so the output queue fills and input backs up
      if (!stall_done && chars_taken >= STALL_AT) begin
        stall_left = STALL_LEN;
        stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        rx_idle = (chars_taken < 150) ? 62 : (chars_taken < 300) ? 23 : 0;
        out_if.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
    mismatches    = 0;
    chars_sent    = 0;
    chars_taken   = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    stall_done    = 1'b0;
    clear_escape();

    // field extremes
    add_char(16'h0000, 1'b0);
    add_char(16'hFFFF, 1'b0);
    // full escape, mixed case digits
    add_text("\\u12aF", 1'b0);
    // a space stops the digit scan; a sign and x follow
    add_text("\\u1 -x", 1'b0);
    // backslash then ordinary char
    add_text("\\x", 1'b0);
    // double backslash into an escape cut off by end of text
    add_text("\\\\uF0", 1'b1);
    // lone backslash at end of text
    add_text("\\", 1'b1);
    // escape with no digits, cut off
    add_text("\\ug", 1'b1);
    // two backslashes, the second one last
    add_text("\\\\", 1'b1);

    while (text_q.size() < TARGET_CHARS) add_random_text();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
